// ----- rtl/core/ascd_pkg.sv -----
// ----------------------------------------------------------------------------
// ascd_pkg
// Shared types, constants and AES helper functions for the sector decryptor.
// ----------------------------------------------------------------------------
package ascd_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int NBLK_RAW = SECTOR_BYTES / 16;
  localparam int NBLOCKS = (NBLK_RAW < 1) ? 1 : NBLK_RAW;
  localparam int BIDX_W = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
  localparam int RK_DEPTH = 15;
  localparam int RK_AW = 4;
  localparam int QDEPTH = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd4;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  // One queued job for the cipher engine.
  typedef struct packed {
    logic         first;
    logic         last;
    logic [127:0] tweak;
    logic [127:0] cipher;
  } job_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_TWEAK,
    ENG_DATA
  } eng_state_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r = r ^ x;
      x = xt(x);
    end
    gmul = r;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = tbl[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = tbl[x];
  endfunction

  // Inverse ShiftRows followed by inverse SubBytes; byte i sits in bits 8i+7:8i.
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[8*(r+4*((c+r)%4)) +: 8] = inv_sbox(s[8*(r+4*c) +: 8]);
      end
    end
    inv_shift_sub = o;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      o[32*c +: 8]    = gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
      o[32*c+8 +: 8]  = gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
      o[32*c+16 +: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
      o[32*c+24 +: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14);
    end
    inv_mix = o;
  endfunction

endpackage

// ----- rtl/core/ascd_keysched.sv -----
// ----------------------------------------------------------------------------
// ascd_keysched
// Holds the key registers and expands the round keys one word per cycle.
// ----------------------------------------------------------------------------
module ascd_keysched (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ascd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic [ascd_pkg::RK_AW-1:0]     rk_addr,
  output logic [127:0]                   rk_data,
  output logic [3:0]                     nrounds,
  output logic                           keys_busy
);
  import ascd_pkg::*;

  logic [63:0]  key_word [4];
  logic [1:0]   key_mode;
  // One bank per word position of a round key, so each bank is read at one address.
  logic [31:0]  rk_b0 [RK_DEPTH];
  logic [31:0]  rk_b1 [RK_DEPTH];
  logic [31:0]  rk_b2 [RK_DEPTH];
  logic [31:0]  rk_b3 [RK_DEPTH];
  logic [5:0]   widx;
  logic [3:0]   nk;
  logic [5:0]   total;
  logic [7:0]   rcon;
  logic [2:0]   mcnt;
  logic [31:0]  prev;
  logic [31:0]  back;
  logic [31:0]  temp;
  logic [31:0]  new_word;
  logic [31:0]  kword;
  logic         busy;
  logic [5:0]   back_addr;

  // The previous word and the word nk back are read from a small memory; nk at most 8.
  logic [31:0]  hist [8];

  always_comb begin
    unique case (key_mode)
      MODE_128: nk = 4'd4;
      MODE_192: nk = 4'd6;
      default:  nk = 4'd8;
    endcase
  end
  assign total = 6'(4 * ({2'b00, nk} + 6'd7));
  assign back_addr = 6'(widx - {2'b00, nk});

  always_comb begin
    kword = widx[0] ? key_word[widx[2:1]][63:32] : key_word[widx[2:1]][31:0];
  end

  assign prev = hist[widx[2:0] - 3'd1];
  assign back = hist[back_addr[2:0]];
  // Count of words since the last rcon step, so i % nk needs no divider.
  always_comb begin
    temp = prev;
    if (mcnt == 3'd0) begin
      temp = {sbox(prev[7:0]), sbox(prev[31:24]), sbox(prev[23:16]),
              sbox(prev[15:8]) ^ rcon};
    end else if (nk == 4'd8 && mcnt == 3'd4) begin
      temp = {sbox(prev[31:24]), sbox(prev[23:16]), sbox(prev[15:8]), sbox(prev[7:0])};
    end
  end
  assign new_word = (widx < {2'b00, nk}) ? kword : (back ^ temp);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word[0] <= '0;
      key_word[1] <= '0;
      key_word[2] <= '0;
      key_word[3] <= '0;
      key_mode    <= MODE_128;
      busy        <= 1'b1;
      widx        <= '0;
      mcnt        <= '0;
      rcon        <= 8'h01;
    end else if (cfg_we && cfg_index <= REG_MODE) begin
      if (cfg_index == REG_MODE) key_mode <= cfg_data[1:0];
      else key_word[cfg_index[1:0]] <= cfg_data;
      busy <= 1'b1;
      widx <= '0;
      mcnt <= '0;
      rcon <= 8'h01;
    end else if (busy) begin
      unique case (widx[1:0])
        2'd0: rk_b0[widx[5:2]] <= new_word;
        2'd1: rk_b1[widx[5:2]] <= new_word;
        2'd2: rk_b2[widx[5:2]] <= new_word;
        default: rk_b3[widx[5:2]] <= new_word;
      endcase
      hist[widx[2:0]]    <= new_word;
      widx               <= widx + 6'd1;
      if (widx >= {2'b00, nk}) begin
        if (mcnt == 3'd0) rcon <= xt(rcon);
      end
      if (widx + 6'd1 >= {2'b00, nk}) begin
        mcnt <= (mcnt + 3'd1 == nk[2:0] || (nk == 4'd8 && mcnt == 3'd7) ||
                 widx + 6'd1 == {2'b00, nk}) ? 3'd0 : mcnt + 3'd1;
      end
      if (widx + 6'd1 == total) busy <= 1'b0;
    end
  end

  // Round key read: four words, registered.
  always_ff @(posedge clk) begin
    rk_data <= {rk_b3[rk_addr], rk_b2[rk_addr], rk_b1[rk_addr], rk_b0[rk_addr]};
  end

  assign nrounds   = 4'(nk + 4'd6);
  assign keys_busy = busy;

  logic unused_ok;
  assign unused_ok = ^back_addr;
endmodule

// ----- rtl/core/ascd_front.sv -----
// ----------------------------------------------------------------------------
// ascd_front
// Accepts ciphertext beats, tracks the block position and queues jobs.
// ----------------------------------------------------------------------------
module ascd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [191:0]  in_data,
  output logic          job_valid,
  input  logic          job_ready,
  output ascd_pkg::job_t job
);
  import ascd_pkg::*;

  logic [BIDX_W-1:0] bidx;
  job_t              q [QDEPTH];
  logic              wp, rp;
  logic [1:0]        cnt;
  logic              push, pop;
  job_t              nj;
  logic              is_last;

  assign in_ready = (cnt != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = job_valid && job_ready;
  assign is_last  = (32'(bidx) + 1 >= NBLOCKS);

  always_comb begin
    nj.first  = (bidx == '0);
    nj.last   = is_last;
    nj.tweak  = {64'd0, in_data[63:0]};
    nj.cipher = {in_data[191:128], in_data[127:64]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bidx <= '0;
      wp   <= 1'b0;
      rp   <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) begin
        bidx <= is_last ? '0 : bidx + 1'b1;
        wp   <= ~wp;
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= nj;
  end

  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];
endmodule

// ----- rtl/core/ascd_engine.sv -----
// ----------------------------------------------------------------------------
// ascd_engine
// Iterative AES decryption, one round per cycle, with tweak mask and chaining.
// ----------------------------------------------------------------------------
module ascd_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  ascd_pkg::job_t             job,
  input  logic                       keys_busy,
  input  logic [3:0]                 nrounds,
  output logic [ascd_pkg::RK_AW-1:0] rk_addr,
  input  logic [127:0]               rk_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [127:0]               out_plain,
  output logic                       out_last
);
  import ascd_pkg::*;

  eng_state_t        state, state_next;
  logic [127:0]      st;
  logic [127:0]      mask;
  logic [127:0]      chain;
  logic [127:0]      tval;
  logic [3:0]        rnd;
  logic              started;
  logic              last_q;
  logic              first_q;
  logic [127:0]      cipher_q;
  logic [127:0]      dec;
  logic              done;
  logic              take;
  logic              out_free;
  logic              emit;

  // The round key address runs one step ahead; the memory output is registered.
  assign done = (rnd == 4'd0) && started;
  assign out_free = !out_valid || out_ready;
  assign emit = (state == ENG_DATA) && done && out_free;
  assign take = job_valid && !keys_busy && state == ENG_IDLE;
  assign job_ready = take;
  assign dec = st ^ rk_data;

  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE:  if (take) state_next = job.first ? ENG_TWEAK : ENG_DATA;
      ENG_TWEAK: if (done) state_next = ENG_DATA;
      ENG_DATA:  if (emit) state_next = ENG_IDLE;
      default:   state_next = ENG_IDLE;
    endcase
  end

  always_comb begin
    rk_addr = rnd - 4'd1;
    if (state == ENG_IDLE || (done && state == ENG_TWEAK)) rk_addr = nrounds;
    // A finished block waiting for the output keeps round key zero in place.
    if (done && state == ENG_DATA) rk_addr = 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ENG_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
      mask      <= '0;
      chain     <= '0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (take) begin
        started  <= 1'b0;
        rnd      <= nrounds;
        last_q   <= job.last;
        first_q  <= job.first;
        cipher_q <= job.cipher;
        st       <= job.first ? job.tweak : (job.cipher ^ mask);
        if (job.first) chain <= job.tweak;
        else tval <= job.cipher ^ mask;
      end else if (state != ENG_IDLE) begin
        started <= 1'b1;
        if (!started) begin
          st  <= inv_shift_sub(dec);
          rnd <= rnd - 4'd1;
        end else if (!done) begin
          st  <= inv_shift_sub(inv_mix(dec));
          rnd <= rnd - 4'd1;
        end else if (state == ENG_TWEAK) begin
          mask    <= dec;
          st      <= cipher_q ^ dec;
          tval    <= cipher_q ^ dec;
          rnd     <= nrounds;
          started <= 1'b0;
        end else if (out_free) begin
          out_plain <= dec ^ chain;
          out_last  <= last_q;
          chain     <= tval;
        end
      end
    end
  end

  logic unused_ok;
  assign unused_ok = first_q;
endmodule

// ----- rtl/core/aes_sector_chained_decrypt.sv -----
// ----------------------------------------------------------------------------
// aes_sector_chained_decrypt
// Sector-chained AES decryption of one 16-byte block per beat.
// ----------------------------------------------------------------------------
// Each block is decrypted in the shared round unit, with 128, 192 or 256-bit keys;
// the first block of a sector goes through it twice, since the tweak is decrypted
// first. After reset and after every write to a key or mode register the key
// schedule is rebuilt, one word per cycle, and no block is started meanwhile.
// Input beats queue two deep while the round unit works; one finished block
// waits in the output register while the round unit goes on with the next one.
module aes_sector_chained_decrypt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ascd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [191:0]                   s_tdata,  // sector_number, cipher_low, cipher_high
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [127:0]                   m_tdata,  // plain_low, plain_high
  output logic                           m_tlast   // sector_last
);
  import ascd_pkg::*;

  logic                jv, jr;
  job_t                jb;
  logic [RK_AW-1:0]    rka;
  logic [127:0]        rkd;
  logic [3:0]          nr;
  logic                kb;

  ascd_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .job_valid(jv), .job_ready(jr), .job(jb)
  );

  ascd_keysched u_keys (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .rk_addr(rka), .rk_data(rkd), .nrounds(nr), .keys_busy(kb)
  );

  ascd_engine u_eng (
    .clk(clk), .rst(rst), .job_valid(jv), .job_ready(jr), .job(jb), .keys_busy(kb),
    .nrounds(nr), .rk_addr(rka), .rk_data(rkd), .out_valid(m_tvalid),
    .out_ready(m_tready), .out_plain(m_tdata), .out_last(m_tlast)
  );
endmodule

// ----- bench/tb_aes_sector_chained_decrypt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes_sector_chained_decrypt
// Streams ciphertext blocks through the sector decryptor under all key sizes
// and checks every plaintext beat against an in-bench sector-chained AES model.
// ----------------------------------------------------------------------------
module tb_aes_sector_chained_decrypt;
  import ascd_pkg::*;

  localparam logic [1:0] MODE_256 = 2'd2;
  localparam logic [1:0] MODE_ODD = 2'd3;
  localparam int DIRECTED_ROWS = 20;

  typedef struct packed {
    logic [127:0] plain;
    logic         last;
  } plain_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [191:0]         s_tdata;   // sector_number, cipher_low, cipher_high
  logic                 m_tvalid;
  logic                 m_tready;
  logic [127:0]         m_tdata;   // plain_low, plain_high
  logic                 m_tlast;   // sector_last

  aes_sector_chained_decrypt dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // Decryptor model state.
  logic [7:0]   fwd_sb [256];
  logic [7:0]   inv_sb [256];
  logic [63:0]  key_words [4];
  logic [1:0]   key_mode;
  logic [7:0]   sched [240];
  int           nrounds;
  int           blk_pos;
  logic [127:0] tweak_mask;
  logic [127:0] chain_val;

  plain_beat_t  pending_plain[$];
  int           errors;
  bit           calm;
  bit           hold_req;
  logic [191:0] directed_rows [DIRECTED_ROWS];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb_aes_sector_chained_decrypt: done, errors");
    $finish;
  end

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic void build_sboxes();
    logic [7:0] v;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      v = 8'h00;
      for (int y = 1; y < 256 && x != 0; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) begin
          v = y[7:0];
          break;
        end
      end
      s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]}
          ^ 8'h63;
      fwd_sb[x] = s;
      inv_sb[s] = x[7:0];
    end
  endfunction

  function automatic void expand_schedule();
    int nk;
    logic [7:0] rc;
    logic [7:0] w [4];
    logic [7:0] f;
    nk = (key_mode == MODE_128) ? 4 : (key_mode == MODE_192) ? 6 : 8;
    nrounds = nk + 6;
    rc = 8'h01;
    for (int k = 0; k < 4 * nk; k++) sched[k] = key_words[k / 8][8 * (k % 8) +: 8];
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      for (int b = 0; b < 4; b++) w[b] = sched[4 * (i - 1) + b];
      if (i % nk == 0) begin
        f = w[0];
        w[0] = fwd_sb[w[1]] ^ rc;
        w[1] = fwd_sb[w[2]];
        w[2] = fwd_sb[w[3]];
        w[3] = fwd_sb[f];
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (nk > 6 && i % nk == 4) begin
        for (int b = 0; b < 4; b++) w[b] = fwd_sb[w[b]];
      end
      for (int b = 0; b < 4; b++) sched[4 * i + b] = sched[4 * (i - nk) + b] ^ w[b];
    end
  endfunction

  function automatic logic [127:0] round_key(input int r);
    logic [127:0] k;
    for (int i = 0; i < 16; i++) k[8 * i +: 8] = sched[16 * r + i];
    return k;
  endfunction

  function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[8 * (r + 4 * ((c + r) % 4)) +: 8] = inv_sb[s[8 * (r + 4 * c) +: 8]];
    return o;
  endfunction

  function automatic logic [127:0] unmix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = s[32 * c + 8 * j +: 8];
      o[32 * c +: 8]      = gf_mul(a[0], 8'd14) ^ gf_mul(a[1], 8'd11) ^
                            gf_mul(a[2], 8'd13) ^ gf_mul(a[3], 8'd9);
      o[32 * c + 8 +: 8]  = gf_mul(a[0], 8'd9) ^ gf_mul(a[1], 8'd14) ^
                            gf_mul(a[2], 8'd11) ^ gf_mul(a[3], 8'd13);
      o[32 * c + 16 +: 8] = gf_mul(a[0], 8'd13) ^ gf_mul(a[1], 8'd9) ^
                            gf_mul(a[2], 8'd14) ^ gf_mul(a[3], 8'd11);
      o[32 * c + 24 +: 8] = gf_mul(a[0], 8'd11) ^ gf_mul(a[1], 8'd13) ^
                            gf_mul(a[2], 8'd9) ^ gf_mul(a[3], 8'd14);
    end
    return o;
  endfunction

  function automatic logic [127:0] aes_inverse(input logic [127:0] blk);
    logic [127:0] s;
    s = blk ^ round_key(nrounds);
    for (int r = nrounds - 1; r >= 1; r--) s = unmix(unshift_unsub(s) ^ round_key(r));
    return unshift_unsub(s) ^ round_key(0);
  endfunction

  // Advances the sector position and returns the plaintext beat for one block.
  function automatic plain_beat_t decrypt_block(input logic [191:0] beat);
    plain_beat_t res;
    logic [127:0] t;
    if (blk_pos == 0) begin
      chain_val  = {64'h0, beat[63:0]};
      tweak_mask = aes_inverse(chain_val);
    end
    t = beat[191:64] ^ tweak_mask;
    res.plain = aes_inverse(t) ^ chain_val;
    chain_val = t;
    res.last = (blk_pos == NBLOCKS - 1);
    blk_pos = res.last ? 0 : blk_pos + 1;
    return res;
  endfunction

  task automatic send_block(input logic [191:0] beat);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_plain.push_back(decrypt_block(beat));
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
  endtask

  // Registers change only with the block idle and its key schedule settled.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    s_tvalid <= 1'b0;
    while (pending_plain.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) key_mode = val[1:0];
    else key_words[idx[1:0]] = val;
    expand_schedule();
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Receiving side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    plain_beat_t want;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (hold_req) begin
        stall = 400;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_plain.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat plain=%h last=%b", $time, m_tdata, m_tlast);
      end else begin
        want = pending_plain.pop_front();
        if (m_tdata[63:0] !== want.plain[63:0]) begin
          errors++;
          $display("%0t: plain_low expected %h got %h", $time, want.plain[63:0], m_tdata[63:0]);
        end
        if (m_tdata[127:64] !== want.plain[127:64]) begin
          errors++;
          $display("%0t: plain_high expected %h got %h", $time, want.plain[127:64],
                   m_tdata[127:64]);
        end
        if (m_tlast !== want.last) begin
          errors++;
          $display("%0t: sector_last expected %b got %b", $time, want.last, m_tlast);
        end
      end
    end
  end

  initial begin
    logic [63:0] key_sets [6][4];
    logic [1:0]  mode_sets [6];
    errors    = 0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_KEY0;
    cfg_data  <= 64'h0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    m_tready  <= 1'b0;

    // Ciphertext extremes and walking patterns; the sector number only
    // matters on the first row.
    directed_rows = '{
      {64'h0, 64'h0, 64'h0},
      {64'h0, 64'h0, 64'hffff_ffff_ffff_ffff},
      {64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0},
      {64'h0, 64'hffff_ffff_ffff_ffff, 64'h0},
      {64'hffff_ffff_ffff_ffff, 64'h0, 64'hffff_ffff_ffff_ffff},
      {64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'h1},
      {64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'h8000_0000_0000_0000},
      {64'h0, 64'h1, 64'h0},
      {64'h8000_0000_0000_0000, 64'h0, 64'h0},
      {64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 64'h0},
      {64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0, 64'h0},
      {64'h0, 64'h0, 64'h0},
      {64'h0, 64'h0, 64'h0},
      {64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0},
      {64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'h0},
      {64'h1, 64'h8000_0000_0000_0000, 64'h0},
      {64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fffe, 64'h0},
      {64'hdead_beef_cafe_f00d, 64'h0, 64'h0},
      {64'h0, 64'hdead_beef_cafe_f00d, 64'h0},
      {64'h3333_cccc_3333_cccc, 64'hcccc_3333_cccc_3333, 64'h0}
    };

    key_sets = '{
      '{64'h0, 64'h0, 64'h0, 64'h0},
      '{64'h0, 64'h0, 64'h0, 64'h0},
      '{64'h0, 64'h0, 64'h0, 64'h0},
      '{'1, '1, '1, '1},
      '{64'h0, 64'h0, 64'h0, 64'h0},
      '{64'h0, 64'h0, 64'h0, 64'h0}
    };
    mode_sets = '{MODE_128, MODE_192, MODE_256, MODE_256, MODE_ODD, MODE_128};
    for (int p = 1; p < 6; p++)
      if (p != 3)
        for (int w = 0; w < 4; w++) key_sets[p][w] = {$urandom, $urandom};

    build_sboxes();
    key_words = '{64'h0, 64'h0, 64'h0, 64'h0};
    key_mode  = MODE_128;
    blk_pos   = 0;
    tweak_mask = '0;
    chain_val  = '0;
    expand_schedule();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) send_block(directed_rows[i]);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        for (int w = 0; w < 4; w++) write_reg(REG_KEY0 + 3'(w), key_sets[p][w]);
        write_reg(REG_MODE, {62'h0, mode_sets[p]});
      end
      for (int k = 0; k < 290; k++) begin
        calm = (k % 100) < 15;
        if (p == 2 && k == 40) hold_req = 1'b1;
        send_block({pick_word(), pick_word(), pick_word()});
      end
    end

    s_tvalid <= 1'b0;
    while (pending_plain.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_aes_sector_chained_decrypt: done, clean");
    end else begin
      $display("tb_aes_sector_chained_decrypt: done, errors");
    end
    $finish;
  end

endmodule
